// File: sv/ssc_pkg.sv
// Shared types, widths and status codes for the case-folding substring search.
// Used by every module of the block; depends on nothing.
package ssc_pkg;

   localparam int CHAR_WIDTH        = 8;
   localparam int PATTERN_MAX_DEF   = 8;
   localparam int POSITION_WIDTH_DEF = 16;
   localparam int PATTERN_BITS      = 64;
   localparam int LENGTH_WIDTH      = 4;
   localparam int START_WIDTH       = 16;
   localparam int STATUS_WIDTH      = 2;
   localparam int CSR_INDEX_WIDTH   = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LENGTH  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CASE    = 2'd2;

   localparam logic [STATUS_WIDTH-1:0] ST_SEARCH  = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_HIT     = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_NO_HIT  = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_DONE    = 2'd3;

   typedef struct packed {
      logic                    text_done;
      logic [START_WIDTH-1:0]  match_start;
      logic [STATUS_WIDTH-1:0] match_status;
   } rsp_item_type;

   // ASCII A-Z to a-z when folding is on; 128-255 untouched
   function automatic logic [CHAR_WIDTH-1:0] fold_char(input logic [CHAR_WIDTH-1:0] c,
                                                        input logic fold_en);
      logic [CHAR_WIDTH-1:0] r;
      r = c;
      if (fold_en && c >= 8'h41 && c <= 8'h5a) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

// File: sv/ssc_cell.sv
// One window cell: holds one text character, passes it on, compares the
// character arriving in it against its expected pattern byte. Uses ssc_pkg.
module ssc_cell
   import ssc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  logic                  clear,
   input  logic [CHAR_WIDTH-1:0] nbr_char,
   input  logic [CHAR_WIDTH-1:0] expect_char,
   input  logic                  in_use,
   input  logic                  fold_en,
   output logic [CHAR_WIDTH-1:0] char_out,
   output logic                  hit
);

   logic [CHAR_WIDTH-1:0] char_ff;
   logic [CHAR_WIDTH-1:0] char_in;

   // compare against the incoming neighbour character
   assign hit = !in_use || (fold_char(nbr_char, fold_en) == fold_char(expect_char, fold_en));

   always_comb begin
      char_in = char_ff;
      if (shift_en) begin
         char_in = clear ? '0 : nbr_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_ff <= '0;
      end else begin
         char_ff <= char_in;
      end
   end

   assign char_out = char_ff;

endmodule

// File: sv/ssc_out_buf.sv
// Two-entry result buffer (output register plus skid stage), so a new item
// is taken while a finished result waits. Uses ssc_pkg for the result type.
module ssc_out_buf
   import ssc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  rsp_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   rsp_item_type skid_item_ff, skid_item_in;
   logic         take;
   logic         put;

   assign in_ready = !skid_valid_ff;
   assign take     = out_valid_ff && out_ready;
   assign put      = in_valid && !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff && !take;
      skid_valid_in = skid_valid_ff;
      out_item_in   = out_item_ff;
      skid_item_in  = skid_item_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_item_in   = skid_item_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (put) begin
         if (!out_valid_ff || take) begin
            out_item_in  = in_item;
            out_valid_in = 1'b1;
         end else begin
            skid_item_in  = in_item;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without output entry");

endmodule

// File: sv/substring_search_case_fold.sv
// Top level of the case-folding substring search: configuration registers,
// chain of window cells, position count, status logic. Uses ssc_pkg,
// ssc_cell and ssc_out_buf.
//
//  channel   ports                         contents
//  req       req_tvalid/tready/tdata/tlast tdata: text_char; tlast: text_last
//  rsp       rsp_tvalid/tready/tdata/tlast tdata: match_status, match_start
//                                          tlast: text_done
//  csr       csr_wr_en/index/wdata         0 pattern, 1 length, 2 case_sensitive
//
// One item per cycle while input is not held off; its result is registered.
// Every cell compares its incoming character in parallel, so the window
// compare sets the rate. Reset clears pattern, length, window and position
// count, sets case_sensitive. A stalled result sits in the output register,
// a second in the skid stage; input is held off only when both are full.
module substring_search_case_fold
   import ssc_pkg::*;
#(
   parameter int PATTERN_MAX    = PATTERN_MAX_DEF,
   parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,  // [7:0] text_char
   input  logic                       req_tlast,  // text_last
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [23:0]                rsp_tdata,  // [1:0] match_status, [17:2] match_start
   output logic                       rsp_tlast,  // text_done
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [PATTERN_BITS-1:0]    csr_wdata
);

   localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = LENGTH_WIDTH'(PATTERN_MAX);
   localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

   logic [PATTERN_BITS-1:0] pattern_ff;
   logic [LENGTH_WIDTH-1:0] length_ff;
   logic                    case_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= '0;
         case_ff    <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PATTERN: pattern_ff <= csr_wdata;
            CSR_LENGTH:  length_ff  <= csr_wdata[LENGTH_WIDTH-1:0];
            CSR_CASE:    case_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic                    accept;
   logic [LENGTH_WIDTH-1:0] len_eff;
   logic                    fold_en;

   assign accept  = req_tvalid && req_tready;
   assign len_eff = (length_ff > LEN_MAX) ? LEN_MAX : length_ff;
   assign fold_en = !case_ff;

   // cell chain: cell 0 takes the new character
   logic [CHAR_WIDTH-1:0] chain [PATTERN_MAX+1];
   logic [PATTERN_MAX-1:0] cell_hit;

   assign chain[0] = req_tdata;

   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
      logic [LENGTH_WIDTH-1:0] pidx;
      logic                    use_i;
      logic [CHAR_WIDTH-1:0]   exp_i;

      assign use_i = LENGTH_WIDTH'(i) < len_eff;
      assign pidx  = len_eff - LENGTH_WIDTH'(1) - LENGTH_WIDTH'(i);
      assign exp_i = pattern_ff[pidx[2:0]*CHAR_WIDTH +: CHAR_WIDTH];

      ssc_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift_en    (accept),
         .clear       (req_tlast),
         .nbr_char    (chain[i]),
         .expect_char (exp_i),
         .in_use      (use_i),
         .fold_en     (fold_en),
         .char_out    (chain[i+1]),
         .hit         (cell_hit[i])
      );
   end

   logic [POSITION_WIDTH-1:0] count_ff, count_in, count_new;
   logic                      found_ff, found_in;
   logic [POSITION_WIDTH-1:0] len_ext;
   logic [POSITION_WIDTH-1:0] start_diff;
   logic [START_WIDTH-1:0]    start_val;
   logic                      match_now;
   rsp_item_type              item;

   assign count_new  = (count_ff == POS_MAX) ? count_ff : count_ff + POSITION_WIDTH'(1);
   assign len_ext    = POSITION_WIDTH'(len_eff);
   assign match_now  = (&cell_hit) && (count_new >= len_ext);
   // empty pattern always starts at offset 0
   assign start_diff = (len_eff == '0) ? '0 : count_new - len_ext;

   if (POSITION_WIDTH > START_WIDTH) begin : g_start_sat
      assign start_val = (|start_diff[POSITION_WIDTH-1:START_WIDTH]) ? '1
                         : start_diff[START_WIDTH-1:0];
   end else begin : g_start_ext
      assign start_val = START_WIDTH'(start_diff);
   end

   always_comb begin
      item.text_done    = req_tlast;
      item.match_start  = '0;
      item.match_status = ST_SEARCH;
      if (found_ff) begin
         item.match_status = ST_DONE;
      end else if (match_now) begin
         item.match_status = ST_HIT;
         item.match_start  = start_val;
      end else if (req_tlast) begin
         item.match_status = ST_NO_HIT;
      end
   end

   always_comb begin
      count_in = count_ff;
      found_in = found_ff;
      if (accept) begin
         count_in = req_tlast ? '0 : count_new;
         found_in = req_tlast ? 1'b0 : (found_ff || match_now);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         found_ff <= found_in;
      end
   end

   rsp_item_type out_item;

   ssc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {6'b0, out_item.match_start, out_item.match_status};
   assign rsp_tlast = out_item.text_done;

   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (!found_ff && count_ff == '0))
      else $error("search state not restarted after last item");

   a_hit_sets_found: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_tlast && !found_ff && match_now) |=> found_ff)
      else $error("match not remembered");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_tlast) |=> (count_ff >= $past(count_ff) && count_ff != '0))
      else $error("position count went backwards");

   a_found_holds: assert property (@(posedge clock) disable iff (reset)
      (found_ff && !accept) |=> found_ff)
      else $error("found flag dropped without an item");

endmodule

// File: test/substring_search_case_fold_test.sv
// Self-checking testbench for substring_search_case_fold: predicts the status of every
// text character from its own window, count and match flag, and checks each result.
// Depends on ssc_pkg and the substring_search_case_fold top level only.
module substring_search_case_fold_test;
   import ssc_pkg::*;

   localparam int RANDOM_ITEMS   = 1750;
   localparam int LONG_FILL      = 40;
   localparam int WATCHDOG_LIMIT = 1000;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata = '0;
   logic                       req_tlast = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [23:0]                rsp_tdata;
   logic                       rsp_tlast;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_PATTERN;
   logic [PATTERN_BITS-1:0]    csr_wdata = '0;

   // predictor copy of configuration and search state
   logic [63:0] cfg_pattern = '0;
   logic [3:0]  cfg_length = '0;
   logic        cfg_case_exact = 1'b1;
   logic [7:0]  recent_chars [PATTERN_MAX_DEF] = '{default: 8'h00};
   logic [15:0] text_pos = '0;
   logic        match_seen = 1'b0;

   rsp_item_type expected_results [$];
   int           mismatch_count = 0;
   int           idle_cycles = 0;
   int           stall_left = 0;
   bit           gaps_on = 1'b0;

   substring_search_case_fold i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [7:0] lower_ascii(input logic [7:0] c);
      if (!cfg_case_exact && c >= 8'h41 && c <= 8'h5a) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   function automatic rsp_item_type search_step(input logic [7:0] c, input logic last);
      rsp_item_type r;
      int           len;
      int           k;
      logic         hit;
      len = (cfg_length > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(cfg_length);
      for (k = PATTERN_MAX_DEF - 1; k > 0; k--) begin
         recent_chars[k] = recent_chars[k-1];
      end
      recent_chars[0] = c;
      if (text_pos != 16'hffff) begin
         text_pos = text_pos + 16'd1;
      end
      r = '0;
      r.match_status = ST_SEARCH;
      r.text_done = last;
      if (match_seen) begin
         r.match_status = ST_DONE;
      end else begin
         hit = (int'(text_pos) >= len);
         for (k = 0; k < len; k++) begin
            if (lower_ascii(cfg_pattern[8*k +: 8]) != lower_ascii(recent_chars[len-1-k])) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            r.match_status = ST_HIT;
            r.match_start = (len == 0) ? 16'd0 : text_pos - 16'(len);
            match_seen = 1'b1;
         end else if (last) begin
            r.match_status = ST_NO_HIT;
         end
      end
      if (last) begin
         recent_chars = '{default: 8'h00};
         text_pos = '0;
         match_seen = 1'b0;
      end
      return r;
   endfunction

   task automatic note_mismatch(input string what, input logic [23:0] want_data,
                                input logic want_last);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s: expected tdata %h tlast %b, got tdata %h tlast %b", $realtime,
                  what, want_data, want_last, rsp_tdata, rsp_tlast);
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            note_mismatch("result with no item pending", 'x, 1'bx);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[1:0] != want.match_status || rsp_tdata[17:2] != want.match_start
                || rsp_tdata[23:18] != 6'd0 || rsp_tlast != want.text_done) begin
               note_mismatch("wrong result", {6'd0, want.match_start, want.match_status},
                             want.text_done);
            end
         end
      end
   end

   // receiver stalls in random bursts while gaps are on
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (gaps_on && !reset && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 13);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic send_char(input logic [7:0] c, input logic last);
      int gap;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(search_step(c, last));
   endtask

   task automatic drain_results;
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_config(input logic [63:0] pattern, input logic [3:0] len,
                               input logic exact);
      drain_results;
      csr_wr_en <= 1'b1;
      csr_index <= CSR_PATTERN;
      csr_wdata <= pattern;
      @(posedge clock);
      csr_index <= CSR_LENGTH;
      csr_wdata <= {60'd0, len};
      @(posedge clock);
      csr_index <= CSR_CASE;
      csr_wdata <= {63'd0, exact};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_pattern = pattern;
      cfg_length = len;
      cfg_case_exact = exact;
   endtask

   // empty pattern from reset matches on the first character of each text
   task automatic test_reset_state;
      send_char(8'h51, 1'b0);
      send_char(8'h00, 1'b1);
      send_char(8'hff, 1'b1);
   endtask

   // exact compare: match on the last character, short text with no match
   task automatic test_exact_match;
      write_config(64'h636261, 4'd3, 1'b1);
      send_char(8'h78, 1'b0);
      send_char(8'h61, 1'b0);
      send_char(8'h62, 1'b0);
      send_char(8'h63, 1'b1);
      send_char(8'h61, 1'b0);
      send_char(8'h62, 1'b1);
   endtask

   // folding on both sides; '@', backquote and bytes above 127 stay as they are
   task automatic test_folding;
      write_config(64'h634261, 4'd3, 1'b0);
      send_char(8'h41, 1'b0);
      send_char(8'h62, 1'b0);
      send_char(8'h43, 1'b0);
      send_char(8'h64, 1'b1);
      write_config(64'h40e1, 4'd2, 1'b0);
      send_char(8'hc1, 1'b0);
      send_char(8'h60, 1'b1);
      send_char(8'he1, 1'b0);
      send_char(8'h40, 1'b1);
   endtask

   // length above eight is clipped to eight
   task automatic test_overlong_length;
      int i;
      write_config(64'hffff_ffff_ffff_ffff, 4'd15, 1'b1);
      for (i = 0; i < 8; i++) begin
         send_char(8'hff, i == 7);
      end
   endtask

   // new pattern applies to the characters already in the window
   task automatic test_config_mid_text;
      write_config(64'h6162, 4'd2, 1'b1);
      send_char(8'h61, 1'b0);
      write_config(64'h6161, 4'd2, 1'b1);
      send_char(8'h61, 1'b1);
   endtask

   // pattern turns up late in a longer text, items back to back
   task automatic test_long_text;
      int i;
      write_config(64'h6261, 4'd2, 1'b1);
      gaps_on = 1'b0;
      for (i = 0; i < LONG_FILL; i++) begin
         send_char(8'h78, 1'b0);
      end
      send_char(8'h61, 1'b0);
      send_char(8'h62, 1'b1);
   endtask

   function automatic logic [7:0] pick_char;
      logic [7:0] pool [6] = '{8'h61, 8'h41, 8'h62, 8'h42, 8'h63, 8'h43};
      if ($urandom_range(0, 7) == 0) begin
         return 8'($urandom_range(0, 255));
      end
      return pool[$urandom_range(0, 5)];
   endfunction

   task automatic test_random_traffic;
      int          sent;
      int          in_phase;
      int          n;
      int          at;
      int          i;
      int          len;
      logic [63:0] pat;
      logic [7:0]  c;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         gaps_on = (sent < RANDOM_ITEMS * 3 / 4);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
         for (i = 0; i < 8; i++) begin
            pat[8*i +: 8] = pick_char();
         end
         write_config(pat, 4'(len), 1'($urandom_range(0, 1)));
         in_phase = 0;
         while (in_phase < 60) begin
            n = $urandom_range(1, 24);
            at = ($urandom_range(0, 1) == 0) ? $urandom_range(0, n - 1) : n;
            for (i = 0; i < n; i++) begin
               if (i >= at && i < at + len && i - at < 8) begin
                  c = pat[8*(i-at) +: 8];
                  if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7a && $urandom_range(0, 1)) begin
                     c = c ^ 8'h20;
                  end
               end else begin
                  c = pick_char();
               end
               send_char(c, i == n - 1 && $urandom_range(0, 7) != 0);
            end
            in_phase += n;
         end
         sent += in_phase;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      gaps_on = 1'b1;
      test_reset_state;
      test_exact_match;
      test_folding;
      test_overlong_length;
      test_config_mid_text;
      test_long_text;
      test_random_traffic;
      drain_results;
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/ssc_pkg.sv
sv/ssc_cell.sv
sv/ssc_out_buf.sv
sv/substring_search_case_fold.sv
test/substring_search_case_fold_test.sv
